// ===== rtl/spq_pkg.sv =====
// Shared types and constants of the sorted priority queue.
package spq_pkg;

  localparam int unsigned ITEM_W       = 32;
  localparam int unsigned PRIO_W       = 32;
  localparam int unsigned COUNT_OUT_W  = 5;
  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W_DEF   = 32;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } spq_action_e;

  typedef struct packed {
    logic push;
    logic pop;
  } spq_cmd_t;

endpackage

// ===== rtl/spq_in_if.sv =====
// Input channel of the sorted priority queue: one push or pop request per item.
interface spq_in_if
  import spq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  spq_action_e                action;
  logic signed [ITEM_W-1:0]   item_data;
  logic signed [PRIO_W-1:0]   item_priority;

  modport source (output valid, output action, output item_data, output item_priority,
                  input ready);
  modport sink   (input valid, input action, input item_data, input item_priority,
                  output ready);
endinterface

// ===== rtl/spq_out_if.sv =====
// Output channel of the sorted priority queue: the queue status after each item.
interface spq_out_if
  import spq_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic signed [ITEM_W-1:0]      head_data;
  logic                          head_valid;
  logic [COUNT_OUT_W-1:0]        entry_count;
  logic                          push_dropped;
  logic                          pop_on_empty;

  modport source (output valid, output head_data, output head_valid, output entry_count,
                  output push_dropped, output pop_on_empty, input ready);
  modport sink   (input valid, input head_data, input head_valid, input entry_count,
                  input push_dropped, input pop_on_empty, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// One slot of the queue: holds an entry and shifts, inserts or keeps it.
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_W_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  spq_cmd_t                 cmd_i,
  input  logic [DATA_WIDTH-1:0]    new_data_i,
  input  logic signed [PRIO_W-1:0] new_prio_i,
  input  logic [DATA_WIDTH-1:0]    left_data_i,
  input  logic signed [PRIO_W-1:0] left_prio_i,
  input  logic                     left_valid_i,
  input  logic                     left_ge_i,
  input  logic [DATA_WIDTH-1:0]    right_data_i,
  input  logic signed [PRIO_W-1:0] right_prio_i,
  input  logic                     right_valid_i,
  output logic [DATA_WIDTH-1:0]    data_o,
  output logic signed [PRIO_W-1:0] prio_o,
  output logic                     valid_o,
  output logic                     ge_o
);

  logic [DATA_WIDTH-1:0]    data_q, data_d;
  logic signed [PRIO_W-1:0] prio_q, prio_d;
  logic                     valid_q, valid_d;

  assign ge_o = valid_q && (prio_q >= new_prio_i);

  always_comb begin
    data_d  = data_q;
    prio_d  = prio_q;
    valid_d = valid_q;
    if (cmd_i.push && !ge_o) begin
      if (left_ge_i) begin
        data_d  = new_data_i;
        prio_d  = new_prio_i;
        valid_d = 1'b1;
      end else begin
        data_d  = left_data_i;
        prio_d  = left_prio_i;
        valid_d = left_valid_i;
      end
    end else if (cmd_i.pop) begin
      data_d  = right_data_i;
      prio_d  = right_prio_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign data_o  = data_q;
  assign prio_o  = prio_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue: a row of slot cells and the result register.
//
// Channel | Direction | Item contents
// in_i    | sink      | action, item_data, item_priority
// out_o   | source    | head_data, head_valid, entry_count, push_dropped, pop_on_empty
//
// Every cell compares its priority with the new one in parallel and shifts, inserts or
// keeps its entry at the accepting edge.
// The result appears in the cycle after acceptance; a new item is taken in the cycle its
// predecessor's result is taken, so one item per cycle is sustained while out_o is ready.
// A stalled result holds in_i off. Reset empties the queue at once; slot contents are not
// cleared.
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_W_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                     in_acc;
  logic                     full;
  logic                     empty;
  spq_cmd_t                 cmd;
  logic [DATA_WIDTH-1:0]    new_data;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     out_valid_q;
  logic                     dropped_q, dropped_d;
  logic                     empty_pop_q, empty_pop_d;
  logic [ITEM_W-1:0]        head_ext;
  logic [CAPACITY-1:0]      valid_vec;
  logic [CAPACITY-1:0]      therm;

  logic [DATA_WIDTH-1:0]    cell_data  [CAPACITY];
  logic signed [PRIO_W-1:0] cell_prio  [CAPACITY];
  logic                     cell_valid [CAPACITY];
  logic                     cell_ge    [CAPACITY];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);

  assign cmd.push = in_acc && (in_i.action == ACT_PUSH) && !full;
  assign cmd.pop  = in_acc && (in_i.action == ACT_POP) && !empty;

  generate
    if (DATA_WIDTH >= ITEM_W) begin : g_data_wide
      assign new_data = {{(DATA_WIDTH - ITEM_W){1'b0}}, in_i.item_data};
      assign head_ext = cell_data[0][ITEM_W-1:0];
    end else begin : g_data_narrow
      assign new_data = in_i.item_data[DATA_WIDTH-1:0];
      assign head_ext = {{(ITEM_W - DATA_WIDTH){1'b0}}, cell_data[0]};
    end
  endgenerate

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0]    l_data, r_data;
      logic signed [PRIO_W-1:0] l_prio, r_prio;
      logic                     l_valid, l_ge, r_valid;

      if (i == 0) begin : g_first
        assign l_data  = new_data;
        assign l_prio  = in_i.item_priority;
        assign l_valid = 1'b1;
        assign l_ge    = 1'b1;
      end else begin : g_mid_l
        assign l_data  = cell_data[i-1];
        assign l_prio  = cell_prio[i-1];
        assign l_valid = cell_valid[i-1];
        assign l_ge    = cell_ge[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign r_data  = '0;
        assign r_prio  = '0;
        assign r_valid = 1'b0;
      end else begin : g_mid_r
        assign r_data  = cell_data[i+1];
        assign r_prio  = cell_prio[i+1];
        assign r_valid = cell_valid[i+1];
      end

      spq_cell #(
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .cmd_i         (cmd),
        .new_data_i    (new_data),
        .new_prio_i    (in_i.item_priority),
        .left_data_i   (l_data),
        .left_prio_i   (l_prio),
        .left_valid_i  (l_valid),
        .left_ge_i     (l_ge),
        .right_data_i  (r_data),
        .right_prio_i  (r_prio),
        .right_valid_i (r_valid),
        .data_o        (cell_data[i]),
        .prio_o        (cell_prio[i]),
        .valid_o       (cell_valid[i]),
        .ge_o          (cell_ge[i])
      );

      assign valid_vec[i] = cell_valid[i];
    end
  endgenerate

  always_comb begin
    count_d     = count_q;
    dropped_d   = dropped_q;
    empty_pop_d = empty_pop_q;
    if (in_acc) begin
      dropped_d   = (in_i.action == ACT_PUSH) && full;
      empty_pop_d = (in_i.action == ACT_POP) && empty;
      if (cmd.push) begin
        count_d = count_q + CNT_W'(1);
      end else if (cmd.pop) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      dropped_q   <= 1'b0;
      empty_pop_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      empty_pop_q <= empty_pop_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  generate
    if (CNT_W >= COUNT_OUT_W) begin : g_cnt_wide
      assign out_o.entry_count = count_q[COUNT_OUT_W-1:0];
    end else begin : g_cnt_narrow
      assign out_o.entry_count = {{(COUNT_OUT_W - CNT_W){1'b0}}, count_q};
    end
  endgenerate

  assign out_o.valid        = out_valid_q;
  assign out_o.head_valid   = cell_valid[0];
  assign out_o.head_data    = cell_valid[0] ? head_ext : '0;
  assign out_o.push_dropped = dropped_q;
  assign out_o.pop_on_empty = empty_pop_q;

  assign therm = ~({CAPACITY{1'b1}} << count_q);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_valid_therm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_vec == therm)
    else $error("Slot valid bits do not match the entry count.");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("An accepted push did not add an entry.");

  a_pop_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("An accepted pop did not remove an entry.");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("An accepted item produced no result.");

endmodule
